/* rtl/core/clru_pkg.sv */
// ----------------------------------------------------------------------------
// clru_pkg
// Types and constants shared by the counter based lru tag table core.
// ----------------------------------------------------------------------------
package clru_pkg;

   localparam int KEY_BITS   = 32;
   localparam int SLOT_BITS  = 3;
   localparam int FRESH_BITS = 15;

   localparam logic [FRESH_BITS-1:0] FRESH_RESET = 15'd10;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   typedef struct packed {
      logic                operation;
      logic [KEY_BITS-1:0] key;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic [SLOT_BITS-1:0] slot;
      logic                 replaced_valid;
      logic [KEY_BITS-1:0]  replaced_key;
   } rsp_type;

endpackage

/* rtl/core/clru_table.sv */
// ----------------------------------------------------------------------------
// clru_table
// Tag, valid and age storage with parallel match, victim select and update.
// ----------------------------------------------------------------------------
module clru_table #(
   parameter int ENTRIES   = 8,
   parameter int KEY_WIDTH = 32,
   parameter int AGE_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  clru_pkg::req_type                 req,
   input  logic [clru_pkg::FRESH_BITS-1:0]   fresh_age,
   output clru_pkg::rsp_type                 rsp
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CMP_W = 33;
   localparam logic [AGE_WIDTH-1:0] AGE_MAX = {1'b0, {(AGE_WIDTH-1){1'b1}}};
   localparam logic [AGE_WIDTH-1:0] AGE_MIN = {1'b1, {(AGE_WIDTH-1){1'b0}}};

   logic [KEY_WIDTH-1:0]        tag_ff   [ENTRIES];
   logic [KEY_WIDTH-1:0]        tag_in   [ENTRIES];
   logic                        valid_ff [ENTRIES];
   logic                        valid_in [ENTRIES];
   logic signed [AGE_WIDTH-1:0] age_ff   [ENTRIES];
   logic signed [AGE_WIDTH-1:0] age_in   [ENTRIES];

   logic [KEY_WIDTH-1:0]        key_t;
   logic signed [AGE_WIDTH-1:0] fresh;
   logic [ENTRIES-1:0]          match;
   logic [ENTRIES-1:0]          empty;
   logic [ENTRIES-1:0]          hit_oh;
   logic [ENTRIES-1:0]          empty_oh;
   logic [ENTRIES-1:0]          min_oh;
   logic [ENTRIES-1:0]          victim_oh;
   logic [IDX_W-1:0]            hit_idx;
   logic [IDX_W-1:0]            victim_idx;
   logic                        rvalid;
   logic [KEY_WIDTH-1:0]        rkey;

   always_comb begin
      key_t = KEY_WIDTH'(req.key);
      if (CMP_W'(fresh_age) > CMP_W'(AGE_MAX)) begin
         fresh = AGE_MAX;
      end else begin
         fresh = AGE_WIDTH'(fresh_age);
      end

      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (tag_ff[i] == key_t);
         empty[i] = !valid_ff[i];
      end

      // first match, first empty, first least age below fresh
      for (int i = 0; i < ENTRIES; i++) begin
         hit_oh[i]   = match[i];
         empty_oh[i] = empty[i];
         min_oh[i]   = age_ff[i] < fresh;
         for (int j = 0; j < ENTRIES; j++) begin
            if (j < i) begin
               if (match[j]) begin
                  hit_oh[i] = 1'b0;
               end
               if (empty[j]) begin
                  empty_oh[i] = 1'b0;
               end
               if (!(age_ff[i] < age_ff[j])) begin
                  min_oh[i] = 1'b0;
               end
            end else if (j > i) begin
               if (age_ff[i] > age_ff[j]) begin
                  min_oh[i] = 1'b0;
               end
            end
         end
      end

      if (|empty) begin
         victim_oh = empty_oh;
      end else if (|min_oh) begin
         victim_oh = min_oh;
      end else begin
         victim_oh = ENTRIES'(1);
      end

      hit_idx    = '0;
      victim_idx = '0;
      rvalid     = 1'b0;
      rkey       = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit_oh[i]) begin
            hit_idx = hit_idx | IDX_W'(i);
         end
         if (victim_oh[i]) begin
            victim_idx = victim_idx | IDX_W'(i);
         end
         if (victim_oh[i] && valid_ff[i]) begin
            rvalid = 1'b1;
            rkey   = rkey | tag_ff[i];
         end
      end

      if (req.operation == clru_pkg::OP_LOOKUP) begin
         rsp.hit            = |hit_oh;
         rsp.slot           = clru_pkg::SLOT_BITS'(hit_idx);
         rsp.replaced_valid = 1'b0;
         rsp.replaced_key   = '0;
      end else begin
         rsp.hit            = 1'b0;
         rsp.slot           = clru_pkg::SLOT_BITS'(victim_idx);
         rsp.replaced_valid = rvalid;
         rsp.replaced_key   = clru_pkg::KEY_BITS'(rkey);
      end

      for (int i = 0; i < ENTRIES; i++) begin
         tag_in[i]   = tag_ff[i];
         valid_in[i] = valid_ff[i];
         age_in[i]   = age_ff[i];
         if (req_valid) begin
            if (req.operation == clru_pkg::OP_LOOKUP) begin
               if (hit_oh[i]) begin
                  age_in[i] = fresh;
               end
            end else begin
               if (victim_oh[i]) begin
                  tag_in[i]   = key_t;
                  valid_in[i] = 1'b1;
                  age_in[i]   = fresh;
               end else if (valid_ff[i] && (age_ff[i] != AGE_MIN)) begin
                  age_in[i] = age_ff[i] - AGE_WIDTH'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         tag_ff[i] <= tag_in[i];
      end
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            age_ff[i]   <= '0;
         end
      end else begin
         for (int i = 0; i < ENTRIES; i++) begin
            valid_ff[i] <= valid_in[i];
            age_ff[i]   <= age_in[i];
         end
      end
   end

endmodule

/* rtl/core/counter_lru_object_cache_policy_core.sv */
// ----------------------------------------------------------------------------
// counter_lru_object_cache_policy_core
// Fully associative tag table with counter based lru replacement.
// ----------------------------------------------------------------------------
//  channel  ports                         direction  handshake
//  request  start, busy, req_data         in         start && !busy
//  result   rsp_strobe, rsp_data          out        one-cycle strobe
//  csr      csr_we, csr_wdata             in         write on csr_we
//
//  one request per cycle; busy stays low
//  request registers into req_ff; the table result and strobe register into rsp_ff and rsp_strobe_ff
//  the table read and update path sets the rate: one compare and age-select pass
//  reset clears valid bits and ages at once; fresh_age returns to 10
// ----------------------------------------------------------------------------
module counter_lru_object_cache_policy_core #(
   parameter int ENTRIES   = 8,
   parameter int KEY_WIDTH = 32,
   parameter int AGE_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  clru_pkg::req_type               req_data,
   output logic                            rsp_strobe,
   output clru_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [clru_pkg::FRESH_BITS-1:0] csr_wdata
);

   logic                            req_valid_ff;
   logic                            req_valid_in;
   clru_pkg::req_type               req_ff;
   clru_pkg::req_type               req_in;
   logic [clru_pkg::FRESH_BITS-1:0] fresh_ff;
   logic [clru_pkg::FRESH_BITS-1:0] fresh_in;
   logic                            rsp_strobe_ff;
   clru_pkg::rsp_type               rsp_ff;
   clru_pkg::rsp_type               rsp_in;

   assign busy         = 1'b0;
   assign req_valid_in = start && !busy;
   assign req_in       = req_data;
   assign fresh_in     = csr_we ? csr_wdata : fresh_ff;

   clru_table #(
      .ENTRIES   (ENTRIES),
      .KEY_WIDTH (KEY_WIDTH),
      .AGE_WIDTH (AGE_WIDTH)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid_ff),
      .req       (req_ff),
      .fresh_age (fresh_ff),
      .rsp       (rsp_in)
   );

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         fresh_ff      <= clru_pkg::FRESH_RESET;
      end else begin
         req_valid_ff  <= req_valid_in;
         rsp_strobe_ff <= req_valid_ff;
         fresh_ff      <= fresh_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
